/* sv/usts_pkg.sv */
`timescale 1ns / 1ps

package usts_pkg;

  // Scan phases
  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_LEFT   = 2'd1;
  localparam logic [1:0] PH_CENTER = 2'd2;
  localparam logic [1:0] PH_RIGHT  = 2'd3;

  // Sensor numbers as carried in echo_sensor
  localparam logic [1:0] SEN_RIGHT  = 2'd0;
  localparam logic [1:0] SEN_CENTER = 2'd1;
  localparam logic [1:0] SEN_LEFT   = 2'd2;

  // Trigger codes
  localparam logic [1:0] TRIG_NONE   = 2'd0;
  localparam logic [1:0] TRIG_LEFT   = 2'd1;
  localparam logic [1:0] TRIG_CENTER = 2'd2;
  localparam logic [1:0] TRIG_RIGHT  = 2'd3;

  // Event kinds
  localparam logic [1:0] MODE_SCAN     = 2'd0;
  localparam logic [1:0] MODE_DISTANCE = 2'd1;
  localparam logic [1:0] MODE_ECHO     = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_MIN_RIGHT  = 3'd0;
  localparam logic [2:0] REG_MIN_CENTER = 3'd1;
  localparam logic [2:0] REG_MIN_LEFT   = 3'd2;
  localparam logic [2:0] REG_IDLE_TICKS = 3'd3;
  localparam logic [2:0] REG_WAIT_TICKS = 3'd4;

  // Register reset values
  localparam logic [7:0] MIN_RESET        = 8'd20;
  localparam logic [7:0] IDLE_TICKS_RESET = 8'd1;
  localparam logic [7:0] WAIT_TICKS_RESET = 8'd5;

  localparam logic [7:0] FLIGHT_MAX = 8'd255;

  // One result item, packed with the last field in the lowest bits
  typedef struct packed {
    logic       pad;
    logic [1:0] scan_phase;
    logic       near_left;
    logic       near_center;
    logic       near_right;
    logic [7:0] range_left;
    logic [7:0] range_center;
    logic [7:0] range_right;
    logic [1:0] trigger;
  } result_t;

endpackage

/* sv/ultrasonic_three_sensor_scanner_unit.sv */
`timescale 1ns / 1ps
// Each result is registered in the output register (skid register on a stall).
// Throughput: one event per cycle while s_tready is high; a two-entry output
// buffer (result register plus skid register) keeps s_tready high while one
// result waits downstream. Reset: synchronous rst restores register defaults,
// idle phase, zero ranges, and empties the output buffer. cfg_ready is tied high.

module ultrasonic_three_sensor_scanner_unit import usts_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  // event stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [1:0] echo_sensor, [2] echo_level, [7:3] zero
  input  logic [1:0]  s_tuser,   // [1:0] mode
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [1:0] trigger, [9:2] range_right,
                                 // [17:10] range_center, [25:18] range_left,
                                 // [26] near_right, [27] near_center,
                                 // [28] near_left, [30:29] scan_phase, [31] zero
);

  result_t result;
  result_t out_data;
  result_t skid_data;
  logic    out_valid;
  logic    skid_valid;
  logic    in_xfer;
  logic    out_xfer;

  assign cfg_ready = 1'b1;
  assign s_tready  = !skid_valid;
  assign in_xfer   = s_tvalid && s_tready;
  assign out_xfer  = out_valid && m_tready;

  usts_core u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg_write   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .step        (in_xfer),
    .mode        (s_tuser),
    .echo_sensor (s_tdata[1:0]),
    .echo_level  (s_tdata[2]),
    .result      (result)
  );

  // Track buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (!out_valid || out_xfer) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (out_xfer) begin
        out_valid  <= skid_valid;
        skid_valid <= 1'b0;
      end
    end
  end

  // Move result payloads; skid data drains into the output register
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      if (!out_valid || out_xfer) begin
        out_data <= result;
      end else begin
        skid_data <= result;
      end
    end else if (out_xfer && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_data;

endmodule

/* sv/usts_core.sv */
`timescale 1ns / 1ps

module usts_core import usts_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       step,
  input  logic [1:0] mode,
  input  logic [1:0] echo_sensor,
  input  logic       echo_level,
  output result_t    result
);

  logic [7:0] min_right, min_center, min_left, idle_ticks, wait_ticks;

  logic [1:0] phase, phase_next;
  logic [7:0] tick_delay, tick_delay_next;
  logic [7:0] flight_count, flight_count_next;
  logic [7:0] captured_flight, captured_flight_next;
  logic       echo_armed, echo_armed_next;
  logic [7:0] range_right, range_right_next;
  logic [7:0] range_center, range_center_next;
  logic [7:0] range_left, range_left_next;
  logic       near_right, near_right_next;
  logic       near_center, near_center_next;
  logic       near_left, near_left_next;

  logic [1:0] trigger;
  logic [1:0] armed_sensor;
  logic [7:0] delay_dec;

  // Write configuration registers; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      min_right  <= MIN_RESET;
      min_center <= MIN_RESET;
      min_left   <= MIN_RESET;
      idle_ticks <= IDLE_TICKS_RESET;
      wait_ticks <= WAIT_TICKS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MIN_RIGHT:  min_right  <= cfg_data;
        REG_MIN_CENTER: min_center <= cfg_data;
        REG_MIN_LEFT:   min_left   <= cfg_data;
        REG_IDLE_TICKS: idle_ticks <= cfg_data;
        REG_WAIT_TICKS: wait_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // The armed sensor is the one triggered last
  always_comb begin
    unique case (phase)
      PH_LEFT:   armed_sensor = SEN_LEFT;
      PH_CENTER: armed_sensor = SEN_CENTER;
      default:   armed_sensor = SEN_RIGHT;
    endcase
  end

  assign delay_dec = tick_delay - 8'd1;

  // Apply one event to the scanner state
  always_comb begin
    phase_next           = phase;
    tick_delay_next      = tick_delay;
    flight_count_next    = flight_count;
    captured_flight_next = captured_flight;
    echo_armed_next      = echo_armed;
    range_right_next     = range_right;
    range_center_next    = range_center;
    range_left_next      = range_left;
    near_right_next      = near_right;
    near_center_next     = near_center;
    near_left_next       = near_left;
    trigger              = TRIG_NONE;
    case (mode)
      MODE_SCAN: begin
        tick_delay_next = delay_dec;
        if (delay_dec == 8'd0) begin
          unique case (phase)
            PH_IDLE: begin
              trigger         = TRIG_LEFT;
              phase_next      = PH_LEFT;
              tick_delay_next = wait_ticks;
              echo_armed_next = 1'b1;
            end
            PH_LEFT: begin
              range_left_next = captured_flight;
              near_left_next  = captured_flight < min_left;
              trigger         = TRIG_CENTER;
              phase_next      = PH_CENTER;
              tick_delay_next = wait_ticks;
              echo_armed_next = 1'b1;
            end
            PH_CENTER: begin
              range_center_next = captured_flight;
              near_center_next  = captured_flight < min_center;
              trigger           = TRIG_RIGHT;
              phase_next        = PH_RIGHT;
              tick_delay_next   = wait_ticks;
              echo_armed_next   = 1'b1;
            end
            default: begin
              range_right_next = captured_flight;
              near_right_next  = captured_flight < min_right;
              phase_next       = PH_IDLE;
              tick_delay_next  = idle_ticks;
            end
          endcase
        end
      end
      MODE_DISTANCE: begin
        // Saturate the flight count
        if (flight_count != FLIGHT_MAX) begin
          flight_count_next = flight_count + 8'd1;
        end
      end
      MODE_ECHO: begin
        if (echo_armed && echo_sensor == armed_sensor) begin
          if (echo_level) begin
            flight_count_next = 8'd0;
          end else begin
            captured_flight_next = flight_count;
            echo_armed_next      = 1'b0;
          end
        end
      end
      default: ;
    endcase
  end

  // Advance state on each accepted event
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      tick_delay      <= IDLE_TICKS_RESET;
      flight_count    <= 8'd0;
      captured_flight <= 8'd0;
      echo_armed      <= 1'b0;
      range_right     <= 8'd0;
      range_center    <= 8'd0;
      range_left      <= 8'd0;
      near_right      <= 1'b0;
      near_center     <= 1'b0;
      near_left       <= 1'b0;
    end else if (step) begin
      phase           <= phase_next;
      tick_delay      <= tick_delay_next;
      flight_count    <= flight_count_next;
      captured_flight <= captured_flight_next;
      echo_armed      <= echo_armed_next;
      range_right     <= range_right_next;
      range_center    <= range_center_next;
      range_left      <= range_left_next;
      near_right      <= near_right_next;
      near_center     <= near_center_next;
      near_left       <= near_left_next;
    end
  end

  // Build the result from the updated state
  always_comb begin
    result.pad          = 1'b0;
    result.scan_phase   = phase_next;
    result.near_left    = near_left_next;
    result.near_center  = near_center_next;
    result.near_right   = near_right_next;
    result.range_left   = range_left_next;
    result.range_center = range_center_next;
    result.range_right  = range_right_next;
    result.trigger      = trigger;
  end

endmodule

/* sv/usts_checker.sv */
`timescale 1ns / 1ps

module usts_checker import usts_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index,
  input logic [7:0]  cfg_data,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [7:0]  s_tdata,
  input logic [1:0]  s_tuser,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  // Output buffer is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid right after reset");

  // A trigger pulse always leaves the scanner waiting on that sensor
  a_trigger_phase: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[1:0] != TRIG_NONE) |-> (m_tdata[30:29] == m_tdata[1:0]))
    else $error("trigger does not match scan phase");

  // Input back-pressure only while a result is pending
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result changed");

endmodule

bind ultrasonic_three_sensor_scanner_unit usts_checker u_usts_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps

module tb;
  import usts_pkg::*;

  // Codes the package leaves unnamed
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [1:0] SEN_NONE    = 2'd3;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [1:0] mode;
    logic [1:0] sensor;
    logic       level;
  } sensor_evt_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;   // [1:0] echo_sensor, [2] echo_level, [7:3] zero
  logic [1:0]  s_tuser = '0;   // [1:0] mode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // [1:0] trigger, [9:2] range_right, [17:10] range_center,
                               // [25:18] range_left, [26] near_right, [27] near_center,
                               // [28] near_left, [30:29] scan_phase, [31] zero

  ultrasonic_three_sensor_scanner_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #1 clk = ~clk;

  sensor_evt_t event_q[$];
  result_t     result_q[$];
  sensor_evt_t nxt;
  result_t     seen, want;
  int          events_pushed = 0;
  int          results_seen = 0;
  int          errors = 0;
  int          cycles = 0;
  int          src_idle_pct = 20;
  int          snk_stall_pct = 20;

  // Scanner state as predicted from accepted events
  logic [7:0] cfg_regs [5];
  logic [1:0] phase_r;
  logic [7:0] delay_r;
  logic [7:0] flight_r;
  logic [7:0] capture_r;
  logic       armed_r;
  logic [7:0] sensor_range [3];
  logic       sensor_near [3];

  // Phase tracker for the stimulus generator; only scan ticks move it
  logic [1:0] gen_phase;
  logic [7:0] gen_delay;

  function automatic logic [1:0] armed_sensor(input logic [1:0] ph);
    if (ph == PH_LEFT) return SEN_LEFT;
    if (ph == PH_CENTER) return SEN_CENTER;
    return SEN_RIGHT;
  endfunction

  function automatic void latch_range(input logic [1:0] sen, input logic [7:0] minimum);
    sensor_range[sen] = capture_r;
    sensor_near[sen] = capture_r < minimum;
  endfunction

  function automatic result_t scanner_step(input logic [1:0] mode, input logic [1:0] sensor,
                                           input logic level);
    result_t r;
    logic [1:0] trig;
    trig = TRIG_NONE;
    if (mode == MODE_SCAN) begin
      delay_r = delay_r - 8'd1;
      if (delay_r == 8'd0) begin
        case (phase_r)
          PH_IDLE: begin
            trig = TRIG_LEFT;
            phase_r = PH_LEFT;
          end
          PH_LEFT: begin
            latch_range(SEN_LEFT, cfg_regs[REG_MIN_LEFT]);
            trig = TRIG_CENTER;
            phase_r = PH_CENTER;
          end
          PH_CENTER: begin
            latch_range(SEN_CENTER, cfg_regs[REG_MIN_CENTER]);
            trig = TRIG_RIGHT;
            phase_r = PH_RIGHT;
          end
          default: begin
            latch_range(SEN_RIGHT, cfg_regs[REG_MIN_RIGHT]);
            phase_r = PH_IDLE;
          end
        endcase
        // every trigger arms the new sensor and loads the echo wait
        if (trig != TRIG_NONE) begin
          delay_r = cfg_regs[REG_WAIT_TICKS];
          armed_r = 1'b1;
        end else begin
          delay_r = cfg_regs[REG_IDLE_TICKS];
        end
      end
    end else if (mode == MODE_DISTANCE) begin
      if (flight_r != FLIGHT_MAX) flight_r = flight_r + 8'd1;
    end else if (mode == MODE_ECHO) begin
      if (armed_r && sensor == armed_sensor(phase_r)) begin
        if (level) begin
          flight_r = 8'd0;
        end else begin
          capture_r = flight_r;
          armed_r = 1'b0;
        end
      end
    end
    r.pad = 1'b0;
    r.trigger = trig;
    r.range_right = sensor_range[SEN_RIGHT];
    r.range_center = sensor_range[SEN_CENTER];
    r.range_left = sensor_range[SEN_LEFT];
    r.near_right = sensor_near[SEN_RIGHT];
    r.near_center = sensor_near[SEN_CENTER];
    r.near_left = sensor_near[SEN_LEFT];
    r.scan_phase = phase_r;
    return r;
  endfunction

  // Queue one event and advance the generator's view of the scan phase
  function automatic void push_event(input logic [1:0] mode, input logic [1:0] sensor,
                                     input logic level);
    sensor_evt_t ev;
    ev.mode = mode;
    ev.sensor = sensor;
    ev.level = level;
    event_q.push_back(ev);
    events_pushed++;
    if (mode == MODE_SCAN) begin
      gen_delay = gen_delay - 8'd1;
      if (gen_delay == 8'd0) begin
        gen_delay = (gen_phase == PH_RIGHT) ? cfg_regs[REG_IDLE_TICKS] : cfg_regs[REG_WAIT_TICKS];
        gen_phase = gen_phase + 2'd1;
      end
    end
  endfunction

  task automatic write_reg(input logic [2:0] index, input logic [7:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (index <= REG_WAIT_TICKS) cfg_regs[index] = value;
  endtask

  // Hold until every queued event has produced its result, then let the block settle
  task automatic settle();
    while (results_seen < events_pushed) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Measurement rounds with random content, mixed with noise and broken echoes
  task automatic sweep_events(input int count);
    int goal;
    int ticks;
    int shape;
    logic [1:0] armed;
    logic [1:0] start;
    goal = events_pushed + count;
    gen_phase = phase_r;
    gen_delay = delay_r;
    while (events_pushed < goal) begin
      if ($urandom_range(99) < 15) begin
        push_event(2'($urandom_range(3)), 2'($urandom_range(3)), 1'($urandom_range(1)));
      end else begin
        armed = armed_sensor(gen_phase);
        ticks = ($urandom_range(11) == 0) ? $urandom_range(250, 300) : $urandom_range(0, 30);
        shape = $urandom_range(9);
        // shape 8 leaves the echo missing
        if (shape == 9) begin
          push_event(MODE_ECHO, armed, 1'b0);
        end else if (shape < 8) begin
          push_event(MODE_ECHO, armed, 1'b1);
          repeat (ticks)
            push_event(MODE_DISTANCE, 2'($urandom_range(3)), 1'($urandom_range(1)));
          if (shape != 7) push_event(MODE_ECHO, armed, 1'b0);
        end
        // scan ticks until the phase moves on and latches
        start = gen_phase;
        while (gen_phase == start) begin
          if ($urandom_range(3) == 0)
            push_event(MODE_DISTANCE, 2'($urandom_range(3)), 1'($urandom_range(1)));
          push_event(MODE_SCAN, 2'($urandom_range(3)), 1'($urandom_range(1)));
        end
      end
    end
  endtask

  // Event driver: issue queued events, predict each accepted transfer
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready)
        result_q.push_back(scanner_step(s_tuser, s_tdata[1:0], s_tdata[2]));
      if (!s_tvalid || s_tready) begin
        if (event_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          nxt = event_q.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= nxt.mode;
          s_tdata <= {5'd0, nxt.level, nxt.sensor};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input int unsigned want_v,
                             input int unsigned got_v);
    if (want_v != got_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want_v, got_v);
      errors++;
    end
  endtask

  // Result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen++;
        seen = m_tdata;
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %h", $time, m_tdata);
          errors++;
        end else begin
          want = result_q.pop_front();
          check_field("trigger", want.trigger, seen.trigger);
          check_field("range_right", want.range_right, seen.range_right);
          check_field("range_center", want.range_center, seen.range_center);
          check_field("range_left", want.range_left, seen.range_left);
          check_field("near_right", want.near_right, seen.near_right);
          check_field("near_center", want.near_center, seen.near_center);
          check_field("near_left", want.near_left, seen.near_left);
          check_field("scan_phase", want.scan_phase, seen.scan_phase);
        end
      end
      m_tready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    cfg_regs[REG_MIN_RIGHT] = MIN_RESET;
    cfg_regs[REG_MIN_CENTER] = MIN_RESET;
    cfg_regs[REG_MIN_LEFT] = MIN_RESET;
    cfg_regs[REG_IDLE_TICKS] = IDLE_TICKS_RESET;
    cfg_regs[REG_WAIT_TICKS] = WAIT_TICKS_RESET;
    phase_r = PH_IDLE;
    delay_r = IDLE_TICKS_RESET;
    flight_r = 8'd0;
    capture_r = 8'd0;
    armed_r = 1'b0;
    for (int s = 0; s < 3; s++) begin
      sensor_range[s] = 8'd0;
      sensor_near[s] = 1'b0;
    end
    gen_phase = PH_IDLE;
    gen_delay = IDLE_TICKS_RESET;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed pass on reset settings
    push_event(MODE_UNUSED, SEN_NONE, 1'b1);        // unused mode
    push_event(MODE_ECHO, SEN_RIGHT, 1'b1);         // echo with nothing armed
    push_event(MODE_SCAN, SEN_RIGHT, 1'b0);         // leave idle, trigger left
    push_event(MODE_ECHO, SEN_NONE, 1'b1);          // no such sensor
    push_event(MODE_ECHO, SEN_CENTER, 1'b1);        // foreign echo
    push_event(MODE_ECHO, SEN_LEFT, 1'b1);
    repeat (3) push_event(MODE_DISTANCE, SEN_LEFT, 1'b0);
    push_event(MODE_ECHO, SEN_LEFT, 1'b0);          // capture
    push_event(MODE_ECHO, SEN_LEFT, 1'b1);          // disarmed, ignored
    repeat (5) push_event(MODE_SCAN, SEN_NONE, 1'b1);  // latch left, near
    repeat (5) push_event(MODE_SCAN, SEN_LEFT, 1'b0);  // center echo missing
    repeat (5) push_event(MODE_SCAN, SEN_CENTER, 1'b1);  // back to idle
    push_event(MODE_DISTANCE, SEN_NONE, 1'b1);
    push_event(MODE_ECHO, SEN_RIGHT, 1'b0);         // right still armed while idle
    settle();

    // Random thresholds and short delays, ignored register indexes
    write_reg(REG_MIN_RIGHT, 8'($urandom_range(255)));
    write_reg(REG_MIN_CENTER, 8'($urandom_range(255)));
    write_reg(REG_MIN_LEFT, 8'($urandom_range(255)));
    write_reg(REG_IDLE_TICKS, 8'($urandom_range(1, 4)));
    write_reg(REG_WAIT_TICKS, 8'($urandom_range(1, 6)));
    for (int k = REG_WAIT_TICKS + 1; k < 8; k++) write_reg(k[2:0], 8'($urandom_range(255)));
    sweep_events(300);
    settle();

    // Top thresholds, longest idle, shortest wait; no idling on either side
    src_idle_pct = 0;
    snk_stall_pct = 0;
    write_reg(REG_MIN_RIGHT, 8'd255);
    write_reg(REG_MIN_CENTER, 8'd255);
    write_reg(REG_MIN_LEFT, 8'd255);
    write_reg(REG_IDLE_TICKS, 8'd255);
    write_reg(REG_WAIT_TICKS, 8'd1);
    sweep_events(250);
    settle();

    // Zero thresholds and a zero idle delay that wraps
    src_idle_pct = 20;
    snk_stall_pct = 20;
    write_reg(REG_MIN_RIGHT, 8'd0);
    write_reg(REG_MIN_CENTER, 8'd0);
    write_reg(REG_MIN_LEFT, 8'd0);
    write_reg(REG_IDLE_TICKS, 8'd0);
    write_reg(REG_WAIT_TICKS, 8'd1);
    sweep_events(250);
    settle();

    // Zero wait delay, then longest wait
    write_reg(REG_MIN_LEFT, 8'($urandom_range(255)));
    write_reg(REG_IDLE_TICKS, 8'd2);
    write_reg(REG_WAIT_TICKS, 8'd0);
    sweep_events(150);
    settle();
    write_reg(REG_MIN_RIGHT, 8'($urandom_range(255)));
    write_reg(REG_WAIT_TICKS, 8'd255);
    sweep_events(100);
    settle();

    // Back to random short settings
    write_reg(REG_MIN_CENTER, 8'($urandom_range(255)));
    write_reg(REG_IDLE_TICKS, 8'($urandom_range(1, 3)));
    write_reg(REG_WAIT_TICKS, 8'($urandom_range(1, 4)));
    sweep_events(200);
    settle();

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
